/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/trr_pkg.sv */
// ---------------------------------------------------------------------------
// trr_pkg
// Types and constants shared by the typed record reformatter.
// ---------------------------------------------------------------------------
package trr_pkg;

	localparam int unsigned MAX_TYPES = 8;
	localparam int unsigned CFG_WIDTH = 64;
	localparam int unsigned SLOTS     = 16;

	// fixed slot positions inside one burst of output words
	localparam int unsigned SLOT_SIZE  = 0;   // 4 bytes, little endian
	localparam int unsigned SLOT_TYPE0 = 4;   // type of the first section
	localparam int unsigned SLOT_LEN0  = 5;   // 4 bytes, big endian
	localparam int unsigned SLOT_DATA  = 9;   // the copied raw byte
	localparam int unsigned SLOT_TYPEN = 10;  // type of the section opened after it
	localparam int unsigned SLOT_LENN  = 11;  // 4 bytes, big endian
	localparam int unsigned SLOT_NUL   = 15;  // trailing nul

	localparam logic [7:0] UPPER_A  = 8'h41;
	localparam logic [7:0] UPPER_Z  = 8'h5A;
	localparam logic [7:0] NUL_BYTE = 8'h00;

	typedef enum logic [0:0] {
		REG_TYPE_SEQUENCE = 1'b0,
		REG_TYPE_COUNT    = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] record_size;
		logic        record_end;
	} raw_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       record_done;
		logic       malformed;
	} fmt_word_t;

	typedef struct packed {
		logic [SLOTS-1:0][7:0] slots;
		logic [SLOTS-1:0]      mask;
		logic                  ended;
		logic                  bad;
	} burst_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= UPPER_A) && (c <= UPPER_Z);
	endfunction

endpackage

/* hw/rtl/trr_stream_if.sv */
// ---------------------------------------------------------------------------
// trr_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ---------------------------------------------------------------------------
interface trr_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/trr_core.sv */
// ---------------------------------------------------------------------------
// trr_core
// Input register, record parsing state and the burst builder for one word.
// ---------------------------------------------------------------------------
module trr_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [trr_pkg::CFG_WIDTH-1:0]       type_sequence,
	input  logic [3:0]                          type_count,
	trr_stream_if.sink                          raw,
	output trr_pkg::burst_t                     burst,
	output logic                                burst_valid,
	input  logic                                burst_take
);
	import trr_pkg::*;

	typedef enum logic [1:0] {
		PH_NUL_COPY,
		PH_LEN_GATHER,
		PH_COUNTED,
		PH_LAST
	} phase_t;

	function automatic logic [7:0] type_at(input logic [CFG_WIDTH-1:0] seq,
		input logic [2:0] idx);
		logic [CFG_WIDTH-1:0] sh;
		sh = seq >> {idx, 3'b000};
		return sh[7:0];
	endfunction

	logic                 s1_valid_q;
	raw_word_t            word_s1;
	logic                 in_record_q;
	logic [3:0]           section_index_q;
	phase_t               phase_q;
	logic [1:0]           len_seen_q;
	logic [31:0]          left_q;
	logic [31:0]          consumed_q;
	logic [31:0]          size_q;
	logic [CFG_WIDTH-1:0] seq_q;
	logic [3:0]           cnt_q;

	logic                 first;
	logic                 advance;
	logic [3:0]           cnt_in;
	logic [CFG_WIDTH-1:0] eff_seq;
	logic [3:0]           eff_cnt;
	logic [31:0]          eff_size;
	logic [31:0]          eff_consumed;
	logic [3:0]           eff_si;
	phase_t               eff_phase;
	logic [1:0]           eff_seen;
	logic [31:0]          eff_left;
	logic [7:0]           type0;
	logic [7:0]           last_type;
	logic                 last_upper;
	logic [31:0]          total;
	logic [31:0]          consumed_new;
	logic                 done_head;
	phase_t               ph_after;
	logic [1:0]           seen_after;
	logic [31:0]          left_after;
	logic                 ended;
	logic [3:0]           si_next;
	logic                 last_c;
	logic [7:0]           type_c;
	logic                 open_c;
	logic [31:0]          len_c;
	logic                 bad;
	logic                 nul;

	assign advance     = s1_valid_q && burst_take;
	assign raw.ready   = !s1_valid_q || burst_take;
	assign burst_valid = s1_valid_q;

	always_comb begin
		first        = !in_record_q;
		cnt_in       = (type_count > 4'(MAX_TYPES)) ? 4'(MAX_TYPES) : type_count;
		eff_seq      = first ? type_sequence : seq_q;
		eff_cnt      = first ? cnt_in : cnt_q;
		eff_size     = first ? word_s1.record_size : size_q;
		eff_consumed = first ? 32'd0 : consumed_q;
		eff_si       = first ? 4'd0 : section_index_q;
		eff_seen     = first ? 2'd0 : len_seen_q;
		eff_left     = first ? 32'd0 : left_q;
		type0        = eff_seq[7:0];
		last_type    = type_at(eff_seq, 3'(eff_cnt - 4'd1));
		last_upper   = is_upper(last_type);

		// section opened on the first byte
		if (!first) begin
			eff_phase = phase_q;
		end else if (eff_cnt <= 4'd1) begin
			eff_phase = PH_LAST;
		end else if (is_upper(type0)) begin
			eff_phase = PH_LEN_GATHER;
		end else begin
			eff_phase = PH_NUL_COPY;
		end

		total = eff_size;
		if (eff_cnt != 4'd0) begin
			total = eff_size + {28'd0, eff_cnt} + (last_upper ? 32'd4 : 32'd1);
		end

		consumed_new = eff_consumed + 32'd1;

		done_head  = 1'b0;
		ph_after   = eff_phase;
		seen_after = eff_seen;
		left_after = eff_left;
		unique case (eff_phase)
			PH_NUL_COPY: begin
				done_head = (word_s1.data_byte == NUL_BYTE);
			end
			PH_LEN_GATHER: begin
				left_after = {eff_left[23:0], word_s1.data_byte};
				seen_after = eff_seen + 2'd1;
				if (eff_seen == 2'd3) begin
					if (left_after == 32'd0) begin
						done_head = 1'b1;
					end else begin
						ph_after = PH_COUNTED;
					end
				end
			end
			PH_COUNTED: begin
				left_after = eff_left - 32'd1;
				done_head  = (left_after == 32'd0);
			end
			PH_LAST: begin
			end
			default: begin
			end
		endcase

		ended   = word_s1.record_end || (consumed_new >= eff_size);
		si_next = eff_si + 4'd1;
		last_c  = ({1'b0, si_next} + 5'd1) >= {1'b0, eff_cnt};
		type_c  = last_c ? last_type : type_at(eff_seq, si_next[2:0]);
		// only the last section is still opened once the record has ended
		open_c  = done_head && (last_c || !ended);
		len_c   = eff_size - consumed_new;

		if (open_c) begin
			if (last_c) begin
				ph_after = PH_LAST;
			end else begin
				ph_after   = is_upper(type_c) ? PH_LEN_GATHER : PH_NUL_COPY;
				seen_after = 2'd0;
				left_after = 32'd0;
			end
		end

		bad = (ph_after != PH_LAST) || (consumed_new != eff_size);
		nul = ended && (ph_after == PH_LAST) && (eff_cnt != 4'd0) && !last_upper;

		burst.ended = ended;
		burst.bad   = bad;
		burst.slots = '0;
		burst.mask  = '0;
		for (int i = 0; i < 4; i++) begin
			burst.slots[SLOT_SIZE + i] = total[8*i +: 8];
			burst.slots[SLOT_LEN0 + i] = eff_size[8*(3-i) +: 8];
			burst.slots[SLOT_LENN + i] = len_c[8*(3-i) +: 8];
			burst.mask[SLOT_SIZE + i]  = first;
			burst.mask[SLOT_LEN0 + i]  = first && (eff_cnt == 4'd1) && last_upper;
			burst.mask[SLOT_LENN + i]  = open_c && last_c && last_upper;
		end
		burst.slots[SLOT_TYPE0] = type0;
		burst.mask[SLOT_TYPE0]  = first && (eff_cnt != 4'd0);
		burst.slots[SLOT_DATA]  = word_s1.data_byte;
		burst.mask[SLOT_DATA]   = 1'b1;
		burst.slots[SLOT_TYPEN] = type_c;
		burst.mask[SLOT_TYPEN]  = open_c;
		burst.slots[SLOT_NUL]   = NUL_BYTE;
		burst.mask[SLOT_NUL]    = nul;
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			word_s1 <= raw.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q      <= 1'b0;
			in_record_q     <= 1'b0;
			section_index_q <= 4'd0;
			phase_q         <= PH_NUL_COPY;
			len_seen_q      <= 2'd0;
			left_q          <= 32'd0;
			consumed_q      <= 32'd0;
			size_q          <= 32'd0;
			seq_q           <= '0;
			cnt_q           <= 4'd0;
		end else begin
			if (raw.valid && raw.ready) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				consumed_q <= consumed_new;
				size_q     <= eff_size;
				seq_q      <= eff_seq;
				cnt_q      <= eff_cnt;
				if (ended) begin
					in_record_q     <= 1'b0;
					section_index_q <= 4'd0;
					phase_q         <= PH_NUL_COPY;
					len_seen_q      <= 2'd0;
					left_q          <= 32'd0;
				end else begin
					in_record_q     <= 1'b1;
					section_index_q <= done_head ? si_next : eff_si;
					phase_q         <= ph_after;
					len_seen_q      <= seen_after;
					left_q          <= left_after;
				end
			end
		end
	end

endmodule

/* hw/rtl/trr_serializer.sv */
// ---------------------------------------------------------------------------
// trr_serializer
// Result register holding one burst; hands its words out lowest slot first.
// ---------------------------------------------------------------------------
module trr_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  trr_pkg::burst_t burst,
	input  logic            burst_valid,
	output logic            burst_take,
	trr_stream_if.source    formatted
);
	import trr_pkg::*;

	logic [SLOTS-1:0]      mask_q;
	logic [SLOTS-1:0][7:0] slots_q;
	logic                  ended_q;
	logic                  bad_q;
	logic [SLOTS-1:0]      pick;
	logic                  last;
	logic [7:0]            sel_byte;

	always_comb begin
		pick     = mask_q & (~mask_q + SLOTS'(1));
		last     = (mask_q & (mask_q - SLOTS'(1))) == '0;
		sel_byte = '0;
		for (int i = 0; i < SLOTS; i++) begin
			sel_byte = sel_byte | (pick[i] ? slots_q[i] : 8'h00);
		end
	end

	assign formatted.valid            = |mask_q;
	assign formatted.data.out_byte    = sel_byte;
	assign formatted.data.run_end     = last;
	assign formatted.data.record_done = last && ended_q;
	assign formatted.data.malformed   = last && ended_q && bad_q;

	// reload when empty, or on the last word of the current burst once it is taken
	assign burst_take = !formatted.valid || (formatted.ready && last);

	always_ff @(posedge clk) begin
		if (burst_valid && burst_take) begin
			slots_q <= burst.slots;
			ended_q <= burst.ended;
			bad_q   <= burst.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (burst_valid && burst_take) begin
			mask_q <= burst.mask;
		end else if (formatted.valid && formatted.ready) begin
			mask_q <= mask_q & ~pick;
		end
	end

endmodule

/* hw/rtl/typed_record_reformatter_unit.sv */
// ---------------------------------------------------------------------------
// typed_record_reformatter_unit
// Rewrites raw dictionary records into size-prefixed, typed sections.
// ---------------------------------------------------------------------------
//  channel    dir  word                                   words per item
//  raw        in   data_byte, record_size, record_end     1
//  formatted  out  out_byte, run_end, record_done,        1 to 11
//                  malformed
//  wr_*       in   register index and data                1 write per cycle
//
// One raw word a cycle is accepted while raw.ready is high; each gives 1 to 11
// formatted words, sent one a cycle while formatted.ready is high, so a word with
// many results holds the raw side. Path: input register, serializer burst register.
// The input register takes a new word while a burst is still draining.
// Reset is asynchronous and clears all control state; no clearing pass.
`include "assert_macros.svh"

module typed_record_reformatter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  trr_pkg::reg_index_t            wr_index,
	input  logic [trr_pkg::CFG_WIDTH-1:0]  wr_data,
	trr_stream_if.sink                     raw,
	trr_stream_if.source                   formatted
);
	import trr_pkg::*;

	logic [CFG_WIDTH-1:0] type_sequence_q;
	logic [3:0]           type_count_q;
	burst_t               burst;
	logic                 burst_valid;
	logic                 burst_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_sequence_q <= '0;
			type_count_q    <= 4'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TYPE_SEQUENCE: type_sequence_q <= wr_data;
				REG_TYPE_COUNT:    type_count_q    <= wr_data[3:0];
				default: begin
				end
			endcase
		end
	end

	trr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.type_sequence (type_sequence_q),
		.type_count    (type_count_q),
		.raw           (raw),
		.burst         (burst),
		.burst_valid   (burst_valid),
		.burst_take    (burst_take)
	);

	trr_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst       (burst),
		.burst_valid (burst_valid),
		.burst_take  (burst_take),
		.formatted   (formatted)
	);

	`ASSERT_HOLDS(a_data_slot, burst_valid, burst.mask[SLOT_DATA], "burst without its data word")
	`ASSERT_HOLDS(a_nul_at_end, burst_valid && burst.mask[SLOT_NUL], burst.ended, "nul before end")
	`ASSERT_HOLDS(a_done_last, formatted.valid && formatted.data.record_done,
		formatted.data.run_end, "record done not on last word of its burst")
	`ASSERT_NEXT(a_accept_lands, raw.valid && raw.ready, burst_valid, "accepted word not held")

endmodule
